@@ design/rc_channel_frame_packer_macros.svh @@
// Assertion macros shared by the channel frame packer RTL.
// Include with the bare file name; each macro expands to one concurrent assertion.
`ifndef RC_CHANNEL_FRAME_PACKER_MACROS_SVH
`define RC_CHANNEL_FRAME_PACKER_MACROS_SVH

// Checked on every clock edge outside reset.
`define RCFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define RCFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ design/rcfp_pkg.sv @@
// Package for the channel frame packer: frame constants, queue entry type, CRC-8 step.
// No dependencies.
package rcfp_pkg;

  localparam int unsigned ChanW  = 11;
  localparam int unsigned AccW   = 18;  // 7 pending bits plus one 11-bit channel
  localparam int unsigned QDepth = 2;

  localparam logic [7:0] SYNC_BYTE = 8'hC8;
  localparam logic [7:0] LEN_BYTE  = 8'd24;
  localparam logic [7:0] TYPE_BYTE = 8'h16;
  localparam logic [7:0] CRC_POLY  = 8'hD5;
  localparam logic [3:0] LAST_SLOT = 4'd15;

  // One classified channel request as handed from front to back
  typedef struct packed {
    logic        first;  // channel 0: frame header goes out first
    logic        last;   // channel 15: CRC byte closes the frame
    logic        two;    // two payload bytes completed, else one
    logic [15:0] bytes;  // payload bytes, first one in the low byte
  } rcfp_entry_t;

  // CRC-8, MSB first, one byte
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  localparam logic [7:0] TYPE_CRC = crc8_update(8'h00, TYPE_BYTE);

endpackage

@@ design/rcfp_front.sv @@
// Front end: accepts channel values, packs them LSB-first and classifies each request.
// Depends on rcfp_pkg.
module rcfp_front import rcfp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [ChanW-1:0]  in_value_i,
  input  logic              q_full_i,
  output logic              in_ready_o,
  output logic              push_o,
  output rcfp_entry_t       entry_o
);

  logic [3:0]      slot_q, slot_d;
  logic [6:0]      pend_q, pend_d;
  logic [2:0]      cnt_q, cnt_d;
  logic [AccW-1:0] acc;
  logic [4:0]      cnt_sum;
  logic            two;
  logic            is_first;
  logic            is_last;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Append the new channel above the pending bits
  always_comb begin
    is_first = (slot_q == '0);
    is_last  = (slot_q == LAST_SLOT);
    acc      = {{(AccW-7){1'b0}}, pend_q}
             | ({{(AccW-ChanW){1'b0}}, in_value_i} << cnt_q);
    cnt_sum  = {2'b00, cnt_q} + 5'd11;
    two      = cnt_sum[4];
    slot_d   = slot_q + 4'd1;
    cnt_d    = cnt_sum[2:0];
    pend_d   = two ? {5'b0, acc[17:16]} : acc[14:8];
    if (is_last) begin
      pend_d = '0;
      cnt_d  = '0;
    end
    entry_o.first = is_first;
    entry_o.last  = is_last;
    entry_o.two   = two;
    entry_o.bytes = acc[15:0];
  end

  // Packing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      pend_q <= '0;
      cnt_q  <= '0;
    end else if (push_o) begin
      slot_q <= slot_d;
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

@@ design/rcfp_queue.sv @@
// Short request queue between the front and back ends.
// Depends on rcfp_pkg.
module rcfp_queue import rcfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  rcfp_entry_t entry_i,
  input  logic        pop_i,
  output rcfp_entry_t head_o,
  output logic        full_o,
  output logic        empty_o
);

  localparam int unsigned PtrW = $clog2(QDepth);

  rcfp_entry_t           mem_q [QDepth];
  logic [PtrW-1:0]       wptr_q, rptr_q;
  logic [PtrW:0]         count_q;

  assign full_o  = (count_q == (PtrW+1)'(QDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rptr_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(QDepth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(QDepth - 1)) ? '0 : rptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

@@ design/rcfp_back.sv @@
// Back end: byte sequencer with running CRC-8 and the output register.
// Depends on rcfp_pkg.
module rcfp_back import rcfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  rcfp_entry_t head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        run_last_o,
  output logic        frame_end_o
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_SYNC, PH_LEN, PH_TYPE, PH_B0, PH_B1, PH_CRC
  } phase_e;

  phase_e     phase_q, phase_d, phase_eff, phase_nxt;
  logic [7:0] crc_q, crc_d;
  logic       out_valid_q;
  logic [7:0] byte_q, byte_d;
  logic       last_q, end_q, end_d;
  logic       advance;
  logic       done;

  assign advance = head_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o   = advance && done;

  // Pick the byte for the current step of the head request
  always_comb begin
    phase_eff = (phase_q == PH_IDLE) ? (head_i.first ? PH_SYNC : PH_B0) : phase_q;
    phase_nxt = PH_IDLE;
    byte_d    = 8'h00;
    crc_d     = crc_q;
    end_d     = 1'b0;
    done      = 1'b0;
    unique case (phase_eff)
      PH_SYNC: begin
        byte_d    = SYNC_BYTE;
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        byte_d    = LEN_BYTE;
        phase_nxt = PH_TYPE;
      end
      PH_TYPE: begin
        byte_d    = TYPE_BYTE;
        crc_d     = TYPE_CRC;
        phase_nxt = PH_B0;
      end
      PH_B0: begin
        byte_d = head_i.bytes[7:0];
        crc_d  = crc8_update(crc_q, byte_d);
        if (head_i.two) begin
          phase_nxt = PH_B1;
        end else if (head_i.last) begin
          phase_nxt = PH_CRC;
        end else begin
          done = 1'b1;
        end
      end
      PH_B1: begin
        byte_d = head_i.bytes[15:8];
        crc_d  = crc8_update(crc_q, byte_d);
        if (head_i.last) begin
          phase_nxt = PH_CRC;
        end else begin
          done = 1'b1;
        end
      end
      PH_CRC: begin
        byte_d = crc_q;
        crc_d  = 8'h00;
        end_d  = 1'b1;
        done   = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase
    phase_d = done ? PH_IDLE : phase_nxt;
  end

  // Sequencer state, CRC and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      crc_q       <= '0;
      out_valid_q <= 1'b0;
      byte_q      <= '0;
      last_q      <= 1'b0;
      end_q       <= 1'b0;
    end else if (advance) begin
      phase_q     <= phase_d;
      crc_q       <= crc_d;
      out_valid_q <= 1'b1;
      byte_q      <= byte_d;
      last_q      <= done;
      end_q       <= end_d;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = byte_q;
  assign run_last_o  = last_q;
  assign frame_end_o = end_q;

endmodule

@@ design/rc_channel_frame_packer.sv @@
// Sixteen-channel RC frame packer: top level tying front end, queue and back end.
// Depends on rcfp_pkg, rcfp_front, rcfp_queue, rcfp_back and the macros header.
//
// Channel values (11 bits, channel 0 first) come in one per request and leave as
// a 26-byte frame: sync 0xC8, length 24, type 0x16, 22 LSB-first payload bytes
// and a CRC-8 (poly 0xD5, init 0, over type and payload) flagged on tuser.
// tlast marks the last byte caused by each channel. The output register sends
// one byte per cycle while m_axis_tready is high and a request is queued; a
// channel yields four bytes for channel 0, three for channel 15 and one or two
// otherwise. A two-entry queue lets the next channels be taken while bytes drain.
`include "rc_channel_frame_packer_macros.svh"

module rc_channel_frame_packer import rcfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [10:0] channel_value, [15:11] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,   // run_last
  output logic        m_axis_tuser    // frame_end
);

  rcfp_entry_t entry, head;
  logic        push, pop, q_full, q_empty;

  rcfp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_value_i (s_axis_tdata[ChanW-1:0]),
    .q_full_i   (q_full),
    .in_ready_o (s_axis_tready),
    .push_o     (push),
    .entry_o    (entry)
  );

  rcfp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  rcfp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!q_empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .run_last_o   (m_axis_tlast),
    .frame_end_o  (m_axis_tuser)
  );

  // Checks
  `RCFP_ASSERT(a_crc_closes_run, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast, "CRC byte without tlast")
  `RCFP_ASSERT(a_pop_nonempty, pop |-> !q_empty, "pop from empty queue")
  `RCFP_ASSERT(a_full_stalls_input, q_full |-> !s_axis_tready && !push, "request taken while queue full")
  `RCFP_ASSERT_ALWAYS(a_idle_in_reset, !rst_ni |-> !m_axis_tvalid, "output valid during reset")

endmodule
